FILE: design/cae_pkg.sv
// ---------------------------------------------------------------------------
// Corner accent shader package
// Shared constants, the queue entry type and small helper functions.
// ---------------------------------------------------------------------------
package cae_pkg;

	// Frame geometry.
	localparam int SPOTS_EACH_CORNER = 4;
	localparam int PIXEL_COUNT       = 16;
	localparam int NUM_CORNERS       = 4;
	localparam int PIX_W             = $clog2(PIXEL_COUNT);
	localparam int CORNER_W          = $clog2(NUM_CORNERS);

	// Reset values of the stored settings.
	localparam logic [7:0] FULL_SCALE      = 8'd255;
	localparam logic [7:0] HIGHLIGHT_RESET = 8'd120;
	localparam logic [7:0] RED_RESET       = 8'd0;
	localparam logic [7:0] GREEN_RESET     = 8'd0;
	localparam logic [7:0] BLUE_RESET      = 8'd32;
	localparam logic [7:0] DIMMER_RESET    = 8'd128;

	// Command queue depth.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Incoming request codes.
	localparam logic [1:0] REQ_COLOUR    = 2'd0;
	localparam logic [1:0] REQ_DIMMER    = 2'd1;
	localparam logic [1:0] REQ_HIGHLIGHT = 2'd2;
	localparam logic [1:0] REQ_BOOSTS    = 2'd3;

	// Operations carried out by the back end.
	typedef enum logic [1:0] {
		OP_COLOUR = 2'd0,
		OP_DIMMER = 2'd1,
		OP_BOOSTS = 2'd2
	} cae_op_t;

	// One classified command, with values already saturated.
	typedef struct packed {
		cae_op_t    op;
		logic [7:0] val0;
		logic [7:0] val1;
		logic [7:0] val2;
		logic [7:0] val3;
	} cae_entry_t;

	// Corner that holds a pixel or spot; pixels beyond the last corner use it.
	function automatic logic [CORNER_W-1:0] corner_of(input logic [PIX_W-1:0] idx);
		int c;
		c = int'(idx) / SPOTS_EACH_CORNER;
		if (c > NUM_CORNERS - 1) begin
			c = NUM_CORNERS - 1;
		end
		return c[CORNER_W-1:0];
	endfunction

	// Clamp a signed 16-bit value to 0..255.
	function automatic logic [7:0] sat8(input logic signed [15:0] v);
		logic [7:0] r;
		if (v < 16'sd0) begin
			r = 8'd0;
		end else if (v > 16'sd255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

FILE: design/cae_cmd_if.sv
// ---------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one decoded command per transaction.
// ---------------------------------------------------------------------------
interface cae_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [15:0] value_a;
	logic signed [15:0] value_b;
	logic signed [15:0] value_c;
	logic signed [15:0] value_d;

	modport source (
		output valid, req_type, value_a, value_b, value_c, value_d,
		input  ready
	);
	modport sink (
		input  valid, req_type, value_a, value_b, value_c, value_d,
		output ready
	);
endinterface

FILE: design/cae_pix_if.sv
// ---------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one shaded pixel per transaction.
// ---------------------------------------------------------------------------
interface cae_pix_if;
	logic       valid;
	logic       ready;
	logic [3:0] pixel_index;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       last_pixel;

	modport source (
		output valid, pixel_index, red_out, green_out, blue_out, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_index, red_out, green_out, blue_out, last_pixel,
		output ready
	);
endinterface

FILE: design/cae_front.sv
// ---------------------------------------------------------------------------
// Command front end
// Accepts commands, saturates their values and turns them into queue entries.
// ---------------------------------------------------------------------------
module cae_front
	import cae_pkg::*;
(
	cae_cmd_if.sink     cmd,
	input  logic [7:0]  spot_boost,
	input  logic        q_full,
	output logic        q_push,
	output cae_entry_t  q_data
);

	logic                take;
	logic                idx_ok;
	logic [CORNER_W-1:0] hl_corner;
	logic [7:0]          hl_val [NUM_CORNERS];

	// A command is taken whenever the queue has room.
	assign cmd.ready = !q_full;
	assign take      = cmd.valid && !q_full;

	// A highlight is only valid for spot indices 0..15.
	assign idx_ok    = (cmd.value_a[15:PIX_W] == '0);
	assign hl_corner = corner_of(cmd.value_a[PIX_W-1:0]);

	// A highlight becomes a full boost write: the chosen corner gets the boost.
	always_comb begin
		for (int k = 0; k < NUM_CORNERS; k++) begin
			hl_val[k] = (hl_corner == CORNER_W'(k)) ? spot_boost : 8'd0;
		end
	end

	// Classify the command; an out-of-range highlight is dropped here.
	always_comb begin
		q_data = '0;
		q_push = 1'b0;
		unique case (cmd.req_type)
			REQ_COLOUR: begin
				q_data.op   = OP_COLOUR;
				q_data.val0 = sat8(cmd.value_a);
				q_data.val1 = sat8(cmd.value_b);
				q_data.val2 = sat8(cmd.value_c);
				q_push      = take;
			end
			REQ_DIMMER: begin
				q_data.op   = OP_DIMMER;
				q_data.val0 = sat8(cmd.value_a);
				q_push      = take;
			end
			REQ_HIGHLIGHT: begin
				q_data.op   = OP_BOOSTS;
				q_data.val0 = hl_val[0];
				q_data.val1 = hl_val[1];
				q_data.val2 = hl_val[2];
				q_data.val3 = hl_val[3];
				q_push      = take && idx_ok;
			end
			REQ_BOOSTS: begin
				q_data.op   = OP_BOOSTS;
				q_data.val0 = sat8(cmd.value_a);
				q_data.val1 = sat8(cmd.value_b);
				q_data.val2 = sat8(cmd.value_c);
				q_data.val3 = sat8(cmd.value_d);
				q_push      = take;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

endmodule

FILE: design/cae_queue.sv
// ---------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer between the front and back ends.
// ---------------------------------------------------------------------------
module cae_queue
	import cae_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cae_entry_t push_data,
	input  logic       pop,
	output logic       full,
	output logic       not_empty,
	output cae_entry_t head
);

	cae_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/cae_back.sv
// ---------------------------------------------------------------------------
// Shading back end
// Applies queued commands to the settings and shades the sixteen pixels.
// ---------------------------------------------------------------------------
module cae_back
	import cae_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cae_entry_t q_head,
	output logic       q_pop,
	cae_pix_if.source  pix
);

	// Stored settings.
	logic [7:0] base_red_q;
	logic [7:0] base_green_q;
	logic [7:0] base_blue_q;
	logic [7:0] dimmer_q;
	logic [7:0] boost_q [NUM_CORNERS];

	// Frame sequencer.
	logic             busy_q;
	logic [PIX_W-1:0] cnt_q;
	logic             adv;

	// Pipeline registers.
	logic             valid_s1;
	logic [PIX_W-1:0] idx_s1;
	logic             last_s1;
	logic [7:0]       red_s1;
	logic [7:0]       green_s1;
	logic [7:0]       blue_s1;
	logic [7:0]       gain_s1;
	logic             valid_s2;
	logic [PIX_W-1:0] idx_s2;
	logic             last_s2;
	logic [15:0]      red_s2;
	logic [15:0]      green_s2;
	logic [15:0]      blue_s2;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_idx_q;
	logic             out_last_q;
	logic [7:0]       out_red_q;
	logic [7:0]       out_green_q;
	logic [7:0]       out_blue_q;

	logic [8:0]       gain_sum;

	// Exact floor(x / 255) for x up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	// The whole pipeline moves when the output register is free or drained.
	assign adv = !out_valid_q || pix.ready;

	// The next command is taken once the current frame's last pixel issues.
	assign q_pop = q_valid && (!busy_q || (adv && cnt_q == PIX_W'(PIXEL_COUNT - 1)));

	// Gain of the pixel about to issue; stage 1 saturates it at full scale.
	assign gain_sum = {1'b0, dimmer_q} + {1'b0, boost_q[corner_of(cnt_q)]};

	// Settings update on each popped command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_red_q   <= RED_RESET;
			base_green_q <= GREEN_RESET;
			base_blue_q  <= BLUE_RESET;
			dimmer_q     <= DIMMER_RESET;
			for (int k = 0; k < NUM_CORNERS; k++) begin
				boost_q[k] <= 8'd0;
			end
		end else if (q_pop) begin
			unique case (q_head.op)
				OP_COLOUR: begin
					base_red_q   <= q_head.val0;
					base_green_q <= q_head.val1;
					base_blue_q  <= q_head.val2;
				end
				OP_DIMMER: begin
					dimmer_q <= q_head.val0;
				end
				OP_BOOSTS: begin
					boost_q[0] <= q_head.val0;
					boost_q[1] <= q_head.val1;
					boost_q[2] <= q_head.val2;
					boost_q[3] <= q_head.val3;
				end
				default: begin
					dimmer_q <= dimmer_q;
				end
			endcase
		end
	end

	// Pixel counter: a popped command opens a new frame, otherwise one pixel
	// per advancing cycle while a frame is open.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (adv && busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == PIX_W'(PIXEL_COUNT - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= busy_q;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Stage 1 snapshots the settings, stage 2 multiplies, the output divides.
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1      <= cnt_q;
			last_s1     <= (cnt_q == PIX_W'(PIXEL_COUNT - 1));
			red_s1      <= base_red_q;
			green_s1    <= base_green_q;
			blue_s1     <= base_blue_q;
			gain_s1     <= gain_sum[8] ? FULL_SCALE : gain_sum[7:0];
			idx_s2      <= idx_s1;
			last_s2     <= last_s1;
			red_s2      <= 16'(red_s1) * 16'(gain_s1);
			green_s2    <= 16'(green_s1) * 16'(gain_s1);
			blue_s2     <= 16'(blue_s1) * 16'(gain_s1);
			out_idx_q   <= idx_s2;
			out_last_q  <= last_s2;
			out_red_q   <= div255(red_s2);
			out_green_q <= div255(green_s2);
			out_blue_q  <= div255(blue_s2);
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.pixel_index = out_idx_q;
	assign pix.last_pixel  = out_last_q;
	assign pix.red_out     = out_red_q;
	assign pix.green_out   = out_green_q;
	assign pix.blue_out    = out_blue_q;

endmodule

FILE: design/corner_accent_led_shader_top.sv
// A command's frame passes the queue, pixel sequencer, stage 1, stage 2 and output register.
// Throughput: sixteen pixels per command, one pixel per cycle unless the pixel channel stalls.
// A two-entry command queue lets commands arrive while the previous frame is still streaming.
// An out-of-range highlight is accepted and produces no pixels.
// Reset: arst_n clears every setting to its initial value at once; no clearing pass.
// ---------------------------------------------------------------------------
// Corner accent LED shader
// Top level: configuration register, front end, command queue and back end.
// ---------------------------------------------------------------------------
module corner_accent_led_shader_top
	import cae_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	cae_cmd_if.sink    cmd,
	cae_pix_if.source  pix
);

	logic       [7:0] spot_boost_q;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_not_empty;
	cae_entry_t       q_in;
	cae_entry_t       q_head;

	// Highlight boost register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spot_boost_q <= HIGHLIGHT_RESET;
		end else if (cfg_we) begin
			spot_boost_q <= cfg_wdata;
		end
	end

	cae_front u_front (
		.cmd        (cmd),
		.spot_boost (spot_boost_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	cae_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	cae_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_not_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.pix     (pix)
	);

`ifndef SYNTHESIS
	// The last-pixel flag marks exactly the final pixel of the frame.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid |-> (pix.last_pixel == (pix.pixel_index == PIX_W'(PIXEL_COUNT - 1))))
		else $error("last_pixel does not match pixel index");

	// Within a frame, pixels follow in order without gaps in numbering.
	a_pixel_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready && !pix.last_pixel) |=>
		(!pix.valid || pix.pixel_index == $past(pix.pixel_index) + 4'd1))
		else $error("pixel index out of sequence");

	// The queue is never written while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (!q_full || q_pop))
		else $error("command queue overflow");
`endif

endmodule

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// Corner accent shader testbench
// Sends decoded commands on the command channel and checks every shaded
// pixel against a local model of the colour, dimmer and corner boost state.
// The run covers a directed section, several settings of the highlight boost
// and random traffic with stalls on both channels. It ends with a stretch at
// full rate.
// ---------------------------------------------------------------------------
module testbench
	import cae_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_MAX    = 10;
	localparam int SETTLE_CYCLES = 8;

	// One decoded command as it is driven onto the command channel.
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] c;
		logic signed [15:0] d;
	} command_t;

	// One shaded pixel, as predicted and as seen on the pixel channel.
	typedef struct packed {
		logic [3:0] index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	cae_cmd_if cmd_ch ();
	cae_pix_if pix_ch ();

	corner_accent_led_shader_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.pix       (pix_ch)
	);

	// Local copy of the shader settings.
	logic [7:0] shade_red;
	logic [7:0] shade_green;
	logic [7:0] shade_blue;
	logic [7:0] shade_dimmer;
	logic [7:0] shade_highlight;
	logic [7:0] shade_boost [NUM_CORNERS];

	pixel_t pixels_due [$];
	int     fault_count = 0;
	int     cycle_count = 0;
	bit     idle_en     = 1'b0;

	// Clock generation.
	initial begin : clock_gen
		forever begin
			#2 clk = ~clk;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Clamp a signed 16-bit value into the 0..255 range.
	function automatic logic [7:0] clamp_level(logic signed [15:0] v);
		if (v[15]) begin
			return 8'd0;
		end
		if (v[14:8] != 7'd0) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	// Corner that a pixel or spot belongs to; anything past the last corner uses it.
	function automatic int corner_for(int spot);
		int c;
		c = spot / SPOTS_EACH_CORNER;
		return (c > NUM_CORNERS - 1) ? NUM_CORNERS - 1 : c;
	endfunction

	// Scale one base channel by the clipped gain.
	function automatic logic [7:0] scale_channel(logic [7:0] base, logic [7:0] gain);
		logic [15:0] prod;
		prod = 16'(base) * 16'(gain);
		return 8'(prod / 16'd255);
	endfunction

	// Queue the sixteen pixels of the frame that the current settings give.
	function automatic void queue_frame();
		pixel_t     px;
		logic [8:0] sum;
		logic [7:0] gain;
		int         i;
		for (i = 0; i < PIXEL_COUNT; i++) begin
			sum = 9'(shade_dimmer) + 9'(shade_boost[corner_for(i)]);
			gain = (sum > 9'd255) ? 8'd255 : sum[7:0];
			px.index = 4'(i);
			px.red = scale_channel(shade_red, gain);
			px.green = scale_channel(shade_green, gain);
			px.blue = scale_channel(shade_blue, gain);
			px.last = (i == PIXEL_COUNT - 1);
			pixels_due.push_back(px);
		end
	endfunction

	// Update the settings for one accepted command and queue its frame.
	function automatic void apply_command(command_t c);
		int spot;
		int k;
		case (c.kind)
			REQ_COLOUR: begin
				shade_red = clamp_level(c.a);
				shade_green = clamp_level(c.b);
				shade_blue = clamp_level(c.c);
			end
			REQ_DIMMER: begin
				shade_dimmer = clamp_level(c.a);
			end
			REQ_HIGHLIGHT: begin
				spot = int'($signed(c.a));
				// An index off the strip leaves everything alone and emits nothing.
				if (spot < 0 || spot >= PIXEL_COUNT) begin
					return;
				end
				for (k = 0; k < NUM_CORNERS; k++) begin
					shade_boost[k] = 8'd0;
				end
				shade_boost[corner_for(spot)] = shade_highlight;
			end
			default: begin
				shade_boost[0] = clamp_level(c.a);
				shade_boost[1] = clamp_level(c.b);
				shade_boost[2] = clamp_level(c.c);
				shade_boost[3] = clamp_level(c.d);
			end
		endcase
		queue_frame();
	endfunction

	// Record a failed pixel check, reporting only the first few.
	function automatic void report_fault(string what, pixel_t due, pixel_t seen);
		fault_count++;
		if (fault_count <= REPORT_MAX) begin
			$display("%0t ns %s: expected px %0d rgb %0d/%0d/%0d last %0b, got px %0d rgb %0d/%0d/%0d last %0b",
				$time, what, due.index, due.red, due.green, due.blue, due.last,
				seen.index, seen.red, seen.green, seen.blue, seen.last);
		end
	endfunction

	// Compare each pixel transaction with the oldest pending pixel.
	always @(posedge clk) begin : pixel_checker
		pixel_t seen;
		pixel_t due;
		if (arst_n === 1'b1 && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
			seen.index = pix_ch.pixel_index;
			seen.red = pix_ch.red_out;
			seen.green = pix_ch.green_out;
			seen.blue = pix_ch.blue_out;
			seen.last = pix_ch.last_pixel;
			if (pixels_due.size() == 0) begin
				report_fault("unexpected pixel", '0, seen);
			end else begin
				due = pixels_due.pop_front();
				if (seen !== due) begin
					report_fault("pixel mismatch", due, seen);
				end
			end
		end
	end

	// Pixel side back-pressure: ready drops for random stalls while idling is on.
	initial begin : pixel_sink_pacing
		int hold;
		hold = 0;
		pix_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 7);
				pix_ch.ready <= 1'b0;
			end else begin
				pix_ch.ready <= 1'b1;
			end
		end
	end

	// Drive one command, wait for its transaction and predict its frame.
	// Returns at a falling edge; valid stays high unless a gap was inserted.
	task automatic send_command(command_t c);
		int gap;
		cmd_ch.valid <= 1'b1;
		cmd_ch.req_type <= c.kind;
		cmd_ch.value_a <= c.a;
		cmd_ch.value_b <= c.b;
		cmd_ch.value_c <= c.c;
		cmd_ch.value_d <= c.d;
		do begin
			@(posedge clk);
		end while (cmd_ch.ready !== 1'b1);
		apply_command(c);
		@(negedge clk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Stop sending and wait until every pending pixel has been seen.
	task automatic drain_frames();
		if (cmd_ch.valid === 1'b1) begin
			cmd_ch.valid <= 1'b0;
		end
		while (pixels_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the highlight boost register once the shader is quiet.
	task automatic write_spot_boost(logic [7:0] level);
		drain_frames();
		cfg_we <= 1'b1;
		cfg_wdata <= level;
		@(negedge clk);
		cfg_we <= 1'b0;
		shade_highlight = level;
	endtask

	function automatic command_t make_command(logic [1:0] kind, logic signed [15:0] a,
		logic signed [15:0] b, logic signed [15:0] c, logic signed [15:0] d);
		command_t cmd;
		cmd.kind = kind;
		cmd.a = a;
		cmd.b = b;
		cmd.c = c;
		cmd.d = d;
		return cmd;
	endfunction

	// A colour, dimmer or boost value: mostly in range, often beyond it.
	function automatic logic signed [15:0] pick_level();
		logic signed [15:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'($urandom);
			1: v = 16'($urandom_range(0, 32767)) | 16'h8000;
			2: v = 16'($urandom_range(256, 32767));
			3: begin
				case ($urandom_range(0, 5))
					0: v = 16'sd0;
					1: v = 16'sd255;
					2: v = 16'sd256;
					3: v = -16'sd1;
					4: v = 16'sh7fff;
					default: v = 16'sh8000;
				endcase
			end
			default: v = 16'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	// A spot index: mostly on the strip, sometimes off either end.
	function automatic logic signed [15:0] pick_spot();
		logic signed [15:0] v;
		case ($urandom_range(0, 19))
			0: v = 16'($urandom);
			1: v = 16'($urandom_range(0, 32767)) | 16'h8000;
			2: v = 16'($urandom_range(16, 32767));
			default: v = 16'($urandom_range(0, PIXEL_COUNT - 1));
		endcase
		return v;
	endfunction

	// A random command; fields it does not use carry random noise.
	function automatic command_t random_command();
		command_t cmd;
		int       pick;
		cmd.a = 16'($urandom);
		cmd.b = 16'($urandom);
		cmd.c = 16'($urandom);
		cmd.d = 16'($urandom);
		pick = $urandom_range(0, 19);
		if (pick < 6) begin
			cmd.kind = REQ_COLOUR;
			cmd.a = pick_level();
			cmd.b = pick_level();
			cmd.c = pick_level();
		end else if (pick < 10) begin
			cmd.kind = REQ_DIMMER;
			cmd.a = pick_level();
		end else if (pick < 15) begin
			cmd.kind = REQ_HIGHLIGHT;
			cmd.a = pick_spot();
		end else begin
			cmd.kind = REQ_BOOSTS;
			cmd.a = pick_level();
			cmd.b = pick_level();
			cmd.c = pick_level();
			cmd.d = pick_level();
		end
		return cmd;
	endfunction

	// Directed commands: field extremes, corner boundaries and spots off the strip.
	task automatic test_directed_edges();
		idle_en = 1'b0;
		send_command(make_command(REQ_HIGHLIGHT, -16'sd1, 16'sd5, 16'sd5, 16'sd5));
		send_command(make_command(REQ_HIGHLIGHT, 16'sd16, 16'sd0, 16'sd0, 16'sd0));
		send_command(make_command(REQ_HIGHLIGHT, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff));
		send_command(make_command(REQ_HIGHLIGHT, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0));
		send_command(make_command(REQ_COLOUR, 16'sd255, 16'sd255, 16'sd255, 16'sh7fff));
		send_command(make_command(REQ_HIGHLIGHT, 16'sd0, -16'sd1, -16'sd1, -16'sd1));
		send_command(make_command(REQ_HIGHLIGHT, 16'sd3, 16'sd0, 16'sd0, 16'sd0));
		send_command(make_command(REQ_HIGHLIGHT, 16'sd4, 16'sd0, 16'sd0, 16'sd0));
		send_command(make_command(REQ_HIGHLIGHT, 16'sd11, 16'sd0, 16'sd0, 16'sd0));
		send_command(make_command(REQ_HIGHLIGHT, 16'sd15, 16'sh5555, 16'shaaaa, 16'sh1234));
		send_command(make_command(REQ_COLOUR, 16'sh8000, 16'sh7fff, 16'sd256, 16'shffff));
		send_command(make_command(REQ_COLOUR, -16'sd1, 16'sd0, 16'sd255, 16'sd0));
		send_command(make_command(REQ_COLOUR, 16'sd1, 16'sd128, 16'sd254, 16'sd0));
		send_command(make_command(REQ_DIMMER, -16'sd1, 16'sh7fff, 16'sh8000, 16'sh00ff));
		send_command(make_command(REQ_DIMMER, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
		send_command(make_command(REQ_DIMMER, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0));
		send_command(make_command(REQ_DIMMER, 16'sd255, 16'sd0, 16'sd0, 16'sd0));
		send_command(make_command(REQ_DIMMER, 16'sd127, 16'sd0, 16'sd0, 16'sd0));
		send_command(make_command(REQ_BOOSTS, 16'sd255, 16'sd255, 16'sd255, 16'sd255));
		send_command(make_command(REQ_BOOSTS, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd128));
		send_command(make_command(REQ_BOOSTS, 16'sd1, 16'sd254, 16'sd256, -16'sd1));
		send_command(make_command(REQ_COLOUR, 16'sd200, 16'sd100, 16'sd50, 16'sd0));
		drain_frames();
	endtask

	// Highlights under a range of highlight boost settings, extremes included.
	task automatic test_spot_boost();
		logic [7:0] levels [6];
		int         n;
		int         k;
		levels = '{8'd0, 8'd255, 8'd1, 8'd128, 8'($urandom), HIGHLIGHT_RESET};
		idle_en = 1'b1;
		for (n = 0; n < 6; n++) begin
			write_spot_boost(levels[n]);
			send_command(make_command(REQ_COLOUR, 16'sd255, pick_level(), pick_level(), 16'sd0));
			send_command(make_command(REQ_DIMMER, pick_level(), 16'sd0, 16'sd0, 16'sd0));
			for (k = 0; k < 2; k++) begin
				send_command(make_command(REQ_HIGHLIGHT, 16'($urandom_range(0, PIXEL_COUNT - 1)),
					16'($urandom), 16'($urandom), 16'($urandom)));
			end
		end
	endtask

	// Random traffic in phases, each under its own highlight boost setting.
	task automatic test_random_traffic();
		int phase;
		int n;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_spot_boost(8'd255);
				1: write_spot_boost(8'd0);
				default: write_spot_boost(8'($urandom));
			endcase
			// Every third phase runs without any idling on either side.
			idle_en = (phase % 3 != 2);
			for (n = 0; n < 50; n++) begin
				send_command(random_command());
				// Once per phase the sender waits for the shader to empty.
				if (n == 25) begin
					drain_frames();
				end
			end
		end
	endtask

	// Back-to-back commands with both sides always ready.
	task automatic test_full_rate();
		int n;
		drain_frames();
		idle_en = 1'b0;
		for (n = 0; n < 50; n++) begin
			send_command(random_command());
		end
	endtask

	// Main sequence.
	initial begin : run
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		cmd_ch.valid = 1'b0;
		cmd_ch.req_type = REQ_COLOUR;
		cmd_ch.value_a = 16'sd0;
		cmd_ch.value_b = 16'sd0;
		cmd_ch.value_c = 16'sd0;
		cmd_ch.value_d = 16'sd0;
		shade_red = RED_RESET;
		shade_green = GREEN_RESET;
		shade_blue = BLUE_RESET;
		shade_dimmer = DIMMER_RESET;
		shade_highlight = HIGHLIGHT_RESET;
		for (k = 0; k < NUM_CORNERS; k++) begin
			shade_boost[k] = 8'd0;
		end
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_edges();
		test_spot_boost();
		test_random_traffic();
		test_full_rate();
		drain_frames();

		if (fault_count == 0 && pixels_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
design/cae_pkg.sv
design/cae_cmd_if.sv
design/cae_pix_if.sv
design/cae_front.sv
design/cae_queue.sv
design/cae_back.sv
design/corner_accent_led_shader_top.sv
dv/testbench.sv
